// ===== src/chirp_symbol_generator_core_assert.svh =====
// assertion macros for the chirp symbol generator core
// expects a clock named clk and an active high reset named rst in the including module
`ifndef CHIRP_SYMBOL_GENERATOR_CORE_ASSERT_SVH
`define CHIRP_SYMBOL_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CSG_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define CSG_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== src/csg_pkg.sv =====
// shared types, constants and the sine table generator for the chirp symbol generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csg_pkg;

  // default widths of the phase datapath and the sine table address
  localparam int unsigned PHASE_BITS_DEFAULT      = 24;
  localparam int unsigned TABLE_ADDR_BITS_DEFAULT = 10;

  // fixed field widths
  localparam int unsigned COUNT_BITS  = 15;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 4;

  // register reset values and spread factor limits
  localparam logic [3:0] SF_RESET = 4'd7;
  localparam logic [3:0] SF_MIN   = 4'd5;
  localparam logic [3:0] SF_MAX   = 4'd12;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SPREAD_FACTOR = 2'd0,
    REG_OVERSAMPLE    = 2'd1,
    REG_DOWN_MODE     = 2'd2
  } cfg_reg_t;

  // input word
  typedef struct packed {
    logic        start_req;
    logic [11:0] symbol;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;
    logic                          last;
  } out_word_t;

  // q30 fixed point constants for the table polynomial
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;

  // quarter-wave sine entry, 32767 * sin(pi/2 * q / 2^(abits-2)), evaluated at elaboration
  function automatic logic [14:0] quarter_sin(input int unsigned q, input int unsigned abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned v;
    x  = (PIHALF_Q30 * longint'(q)) >> (abits - 2);
    x2 = (x * x) >> 30;
    p  = ONE_Q30;
    p  = ONE_Q30 - (((x2 * p) >> 30) / 156);
    p  = ONE_Q30 - (((x2 * p) >> 30) / 110);
    p  = ONE_Q30 - (((x2 * p) >> 30) / 72);
    p  = ONE_Q30 - (((x2 * p) >> 30) / 42);
    p  = ONE_Q30 - (((x2 * p) >> 30) / 20);
    p  = ONE_Q30 - (((x2 * p) >> 30) / 6);
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/chirp_symbol_generator_core.sv =====
// chirp symbol generator: a LoRa-style chirp as a stream of i/q samples
// depends on csg_pkg and chirp_symbol_generator_core_assert.svh
//
// usage:
//   in channel (in_valid/in_ready/in_data): a word with start_req set loads the
//   symbol and arms a chirp; it yields no output. Each later word with start_req
//   clear is a tick that yields one sample word; ticks while idle yield nothing.
//   A chirp is 2^(sf+oslog) samples; the final one carries last.
//   out channel (out_valid/out_ready/out_data): in_phase, quadrature, last.
//   config port (cfg_write/cfg_index/cfg_data): spread factor, oversampling log2
//   and down mode, meant to change only while idle.
// pipeline:
//   a tick's sample passes the table stage (phase step and sine table read at
//   the accepting edge), then the sign and output register, to out_data.
//   one word is accepted per cycle while in_ready is high; the phase and
//   frequency adders are combinational and the quarter-wave table has two read
//   ports, one each for sine and cosine.
// reset: the generator is idle, registers are 7, 0, 0, both stages empty.
// stall: while out_ready is low the output and table stages hold their words;
//   in_ready drops once both stages are full and returns as out_ready rises.
`timescale 1ns / 1ps
`default_nettype none

module chirp_symbol_generator_core #(
  parameter int unsigned PHASE_BITS      = csg_pkg::PHASE_BITS_DEFAULT,
  parameter int unsigned TABLE_ADDR_BITS = csg_pkg::TABLE_ADDR_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [csg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire csg_pkg::in_word_t                  in_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      csg_pkg::out_word_t                 out_data
);
  import csg_pkg::*;

  localparam int unsigned P     = PHASE_BITS;
  localparam int unsigned A     = TABLE_ADDR_BITS;
  localparam int unsigned QSIZE = 1 << (A - 2);
  localparam int unsigned SHW   = $clog2(P + 1);
  localparam logic [P-1:0] PONE = P'(1);
  localparam logic [A-2:0] QSIZE_IDX = (A-1)'(QSIZE);

  // configuration registers
  logic [3:0] spread_factor;
  logic [1:0] oversample_log2;
  logic       down_mode;

  // chirp state
  logic [P-1:0]          phase_acc;
  logic [P-1:0]          freq_acc;
  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] fold_index;
  logic                  active;

  logic [P-1:0]          phase_acc_next;
  logic [P-1:0]          freq_acc_next;
  logic [COUNT_BITS-1:0] sample_count_next;
  logic [COUNT_BITS-1:0] fold_index_next;
  logic                  active_next;

  // table stage
  logic        s1_valid;
  logic [14:0] s1_sin;
  logic [14:0] s1_cos;
  logic        s1_sin_neg;
  logic        s1_cos_neg;
  logic        s1_last;

  // handshake
  logic out_free;
  logic s1_free;
  logic in_fire;
  logic produce;

  // datapath signals
  logic [3:0]     sf_eff;
  logic [SHW-1:0] step_sh;
  logic [SHW-1:0] id_sh;
  logic [SHW-1:0] half_sh;
  logic [SHW-1:0] drop_sh;
  logic [11:0]    id;
  logic [12:0]    n_minus_id;
  logic [15:0]    total;
  logic           is_last;
  logic [A-1:0]   addr;
  logic [1:0]     sin_quad;
  logic [1:0]     cos_quad;
  logic [A-3:0]   rem;
  logic [A-2:0]   sin_idx;
  logic [A-2:0]   cos_idx;

  // quarter-wave sine table, constant contents
  logic [14:0] sin_rom [QSIZE+1];

  for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
    assign sin_rom[k] = quarter_sin(k, A);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_factor   <= SF_RESET;
      oversample_log2 <= 2'd0;
      down_mode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPREAD_FACTOR: spread_factor   <= cfg_data;
        REG_OVERSAMPLE:    oversample_log2 <= cfg_data[1:0];
        REG_DOWN_MODE:     down_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: the output stage moves when empty or draining, the table stage when empty or the output moves
  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_valid || out_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;
  assign produce  = in_fire && !in_data.start_req && active;

  // clamp spread factor and derive shift amounts
  always_comb begin
    priority if (spread_factor < SF_MIN) begin
      sf_eff = SF_MIN;
    end else if (spread_factor > SF_MAX) begin
      sf_eff = SF_MAX;
    end else begin
      sf_eff = spread_factor;
    end
    step_sh = SHW'(P) - SHW'(sf_eff) - SHW'({oversample_log2, 1'b0});
    id_sh   = SHW'(P) - SHW'(sf_eff) - SHW'(oversample_log2);
    half_sh = SHW'(P) - SHW'(1) - SHW'(oversample_log2);
    drop_sh = SHW'(P) - SHW'(oversample_log2);
  end

  // start and tick arithmetic
  always_comb begin
    id         = in_data.symbol & 12'((13'd1 << sf_eff) - 13'd1);
    n_minus_id = (13'd1 << sf_eff) - {1'b0, id};
    total      = 16'd1 << (sf_eff + 4'(oversample_log2));
    is_last    = ({1'b0, sample_count} + 16'd1) >= total;

    phase_acc_next    = phase_acc;
    freq_acc_next     = freq_acc;
    sample_count_next = sample_count;
    fold_index_next   = fold_index;
    active_next       = active;

    if (in_fire) begin
      if (in_data.start_req) begin
        freq_acc_next     = (PONE << (step_sh - SHW'(1))) + (P'(id) << id_sh)
                            - (PONE << half_sh);
        phase_acc_next    = '0;
        sample_count_next = '0;
        fold_index_next   = COUNT_BITS'((16'(n_minus_id) << oversample_log2) - 16'd1);
        active_next       = 1'b1;
      end else if (active) begin
        phase_acc_next = phase_acc + freq_acc;
        if (sample_count == fold_index) begin
          freq_acc_next = freq_acc + (PONE << step_sh) - (PONE << drop_sh);
        end else begin
          freq_acc_next = freq_acc + (PONE << step_sh);
        end
        if (is_last) begin
          active_next       = 1'b0;
          sample_count_next = '0;
        end else begin
          sample_count_next = sample_count + COUNT_BITS'(1);
        end
      end
    end
  end

  // chirp state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      freq_acc     <= '0;
      sample_count <= '0;
      fold_index   <= '0;
      active       <= 1'b0;
    end else begin
      phase_acc    <= phase_acc_next;
      freq_acc     <= freq_acc_next;
      sample_count <= sample_count_next;
      fold_index   <= fold_index_next;
      active       <= active_next;
    end
  end

  // table addresses, cosine is a quarter turn ahead
  always_comb begin
    addr     = phase_acc[P-1 -: A];
    sin_quad = addr[A-1 -: 2];
    cos_quad = sin_quad + 2'd1;
    rem      = addr[A-3:0];
    sin_idx  = sin_quad[0] ? QSIZE_IDX - {1'b0, rem} : {1'b0, rem};
    cos_idx  = cos_quad[0] ? QSIZE_IDX - {1'b0, rem} : {1'b0, rem};
  end

  // table stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= produce;
    end
  end

  // table read and sign flags
  always_ff @(posedge clk) begin
    if (produce) begin
      s1_sin     <= sin_rom[sin_idx];
      s1_cos     <= sin_rom[cos_idx];
      s1_sin_neg <= sin_quad[1] ^ down_mode;
      s1_cos_neg <= cos_quad[1];
      s1_last    <= is_last;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // output word with signs applied
  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data.in_phase   <= s1_cos_neg ? -$signed({1'b0, s1_cos}) : $signed({1'b0, s1_cos});
      out_data.quadrature <= s1_sin_neg ? -$signed({1'b0, s1_sin}) : $signed({1'b0, s1_sin});
      out_data.last       <= s1_last;
    end
  end

  // checks
  `include "chirp_symbol_generator_core_assert.svh"

  `CSG_ASSERT_NOW(a_idle_count_clear, !active, sample_count == '0, "count not clear while idle")
  `CSG_ASSERT_NEXT(a_start_arms, in_fire && in_data.start_req, active && phase_acc == '0, "start did not arm")
  `CSG_ASSERT_NEXT(a_last_idles, produce && is_last, !active, "still active after last sample")
  `CSG_ASSERT_NOW(a_no_min_value, out_valid, out_data.in_phase != 16'sh8000 && out_data.quadrature != 16'sh8000, "sample out of range")

endmodule

`default_nettype wire

// ===== sim/chirp_symbol_generator_core_test.sv =====
`timescale 1ns / 1ps

// self-checking testbench for chirp_symbol_generator_core: start and tick words in,
// i/q sample words out, each checked against a bit-exact phase/frequency predictor
// depends on csg_pkg and the core

module chirp_symbol_generator_core_test;
  import csg_pkg::*;

  localparam int unsigned PB = PHASE_BITS_DEFAULT;
  localparam int unsigned AB = TABLE_ADDR_BITS_DEFAULT;
  localparam int unsigned QUARTER = 1 << (AB - 2);
  localparam longint unsigned PHASE_MASK = (64'd1 << PB) - 64'd1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_SAMPLES = 250;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint unsigned RUN_LIMIT_NS = 64'd40_000_000;

  // tracks the generator state and holds the sample words still owed by the core
  class chirp_predictor;
    logic [3:0]      sf_reg;
    logic [1:0]      os_reg;
    logic            down_reg;
    longint unsigned phase;
    longint unsigned freq;
    int unsigned     count;
    int unsigned     fold;
    bit              active;
    int unsigned     sample_total;
    int unsigned     mismatches;
    out_word_t       samples_due[$];
    int              qsin[QUARTER+1];

    function new();
      sf_reg = SF_RESET;
      os_reg = 2'd0;
      down_reg = 1'b0;
      phase = 0;
      freq = 0;
      count = 0;
      fold = 0;
      active = 1'b0;
      sample_total = 0;
      mismatches = 0;
      for (int q = 0; q <= QUARTER; q++) qsin[q] = quarter_wave(q);
    endfunction

    // q30 taylor series of the quarter wave, horner form
    function int quarter_wave(int unsigned q);
      longint unsigned x, x2, p, s, v;
      int unsigned divs[6];
      divs = '{156, 110, 72, 42, 20, 6};
      x = (PIHALF_Q30 * 64'(q)) >> (AB - 2);
      x2 = (x * x) >> 30;
      p = ONE_Q30;
      foreach (divs[i]) p = ONE_Q30 - (((x2 * p) >> 30) / divs[i]);
      s = (x * p) >> 30;
      v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return int'(v);
    endfunction

    // full-wave lookup by quadrant symmetry
    function logic signed [15:0] wave(logic [AB-1:0] k);
      int unsigned r;
      int mag;
      r = k[AB-3:0];
      case (k[AB-1:AB-2])
        2'd0: mag = qsin[r];
        2'd1: mag = qsin[QUARTER - r];
        2'd2: mag = -qsin[r];
        default: mag = -qsin[QUARTER - r];
      endcase
      return mag[15:0];
    endfunction

    function int unsigned spread();
      if (sf_reg < SF_MIN) return SF_MIN;
      if (sf_reg > SF_MAX) return SF_MAX;
      return sf_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [3:0] val);
      case (idx)
        REG_SPREAD_FACTOR: sf_reg = val;
        REG_OVERSAMPLE: os_reg = val[1:0];
        REG_DOWN_MODE: down_reg = val[0];
        default: ;
      endcase
    endfunction

    // advance the generator by one accepted input word
    function void accept_word(in_word_t w);
      int unsigned sf, ol, n, id;
      logic [AB-1:0] addr, cos_addr;
      out_word_t due;
      bit is_last;
      sf = spread();
      ol = os_reg;
      if (w.start_req) begin
        n = 1 << sf;
        id = w.symbol & (n - 1);
        freq = ((64'd1 << (PB - sf - 2 * ol - 1)) + (64'(id) << (PB - sf - ol))
               - (64'd1 << (PB - 1 - ol))) & PHASE_MASK;
        phase = 0;
        count = 0;
        fold = (((n - id) << ol) - 1) & 32'h7FFF;
        active = 1'b1;
        return;
      end
      if (!active) return;

      // sample from the current phase
      addr = AB'(phase >> (PB - AB));
      cos_addr = AB'(addr + QUARTER);
      due.in_phase = wave(cos_addr);
      due.quadrature = down_reg ? -wave(addr) : wave(addr);
      is_last = (count + 1) >= (1 << (sf + ol));
      due.last = is_last;
      samples_due.push_back(due);
      sample_total++;

      // accumulators, with the frequency drop at the fold
      phase = (phase + freq) & PHASE_MASK;
      freq = (freq + (64'd1 << (PB - sf - 2 * ol))) & PHASE_MASK;
      if (count == fold) freq = (freq - (64'd1 << (PB - ol))) & PHASE_MASK;
      if (is_last) begin
        active = 1'b0;
        count = 0;
      end else begin
        count = (count + 1) & 32'h7FFF;
      end
    endfunction

    function void compare_sample(out_word_t got);
      out_word_t want;
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected sample word: i %0d q %0d last %0b",
                   got.in_phase, got.quadrature, got.last);
        return;
      end
      want = samples_due.pop_front();
      if (got.in_phase !== want.in_phase || got.quadrature !== want.quadrature ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("sample mismatch: expected i %0d q %0d last %0b, got i %0d q %0d last %0b",
                   want.in_phase, want.quadrature, want.last,
                   got.in_phase, got.quadrature, got.last);
      end
    endfunction

    function int unsigned outstanding();
      return samples_due.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [1:0]               cfg_index = REG_SPREAD_FACTOR;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_word_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  out_word_t                out_data;
  int unsigned              idle_pct = 0;
  int unsigned              stall_left = 0;
  chirp_predictor           chirps;

  chirp_symbol_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(1, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // output word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) chirps.compare_sample(out_data);
  end

  // send one input word, with an optional gap before it
  task automatic send_word(input logic start, input logic [11:0] sym);
    in_word_t w;
    w.start_req = start;
    w.symbol = sym;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chirps.accept_word(w);
  endtask

  // tick words carry a random, ignored symbol
  task automatic ticks(input int unsigned n);
    repeat (n) send_word(1'b0, 12'($urandom));
  endtask

  // hold the sender until every owed sample is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (chirps.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] sf, input logic [1:0] os, input logic dm);
    cfg_write <= 1'b1;
    cfg_index <= REG_SPREAD_FACTOR;
    cfg_data <= sf;
    @(posedge clk);
    chirps.write_reg(REG_SPREAD_FACTOR, sf);
    cfg_index <= REG_OVERSAMPLE;
    cfg_data <= {2'b00, os};
    @(posedge clk);
    chirps.write_reg(REG_OVERSAMPLE, {2'b00, os});
    cfg_index <= REG_DOWN_MODE;
    cfg_data <= {3'b000, dm};
    @(posedge clk);
    chirps.write_reg(REG_DOWN_MODE, {3'b000, dm});
    cfg_write <= 1'b0;
  endtask

  // random settings, then a few chirps: up to 128 samples mostly complete, some cut short; longer always cut short
  task automatic random_phase(input int unsigned chirp_count);
    logic [3:0] sf;
    logic [1:0] os;
    int unsigned eff, len, roll, n;
    sf = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    eff = (sf < SF_MIN) ? SF_MIN : (sf > SF_MAX) ? SF_MAX : sf;
    os = 2'($urandom_range(0, 3));
    if (eff + os > 7 && $urandom_range(0, 1) == 1) os = 2'd0;
    len = 1 << (eff + os);
    drain();
    set_regs(sf, os, 1'($urandom_range(0, 1)));
    repeat (chirp_count) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) ticks($urandom_range(1, 4));
      send_word(1'b1, 12'($urandom));
      if (len > 128) n = $urandom_range(1, 48);
      else if (roll < 3) n = $urandom_range(1, len - 1);
      else n = len + $urandom_range(0, 2);
      ticks(n);
    end
  endtask

  // stimulus
  initial begin
    int unsigned goal;
    chirps = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, clamped spread factors, fold at the first sample,
    // restart while running, symbol zero, widest settings
    idle_pct = 20;
    ticks(1);
    drain();
    set_regs(4'd0, 2'd0, 1'b1);
    send_word(1'b1, 12'hFFF);
    ticks(3);
    send_word(1'b1, 12'h000);
    ticks(2);
    drain();
    set_regs(4'd15, 2'd0, 1'b0);
    send_word(1'b1, 12'hABC);
    ticks(2);
    drain();
    set_regs(4'd12, 2'd3, 1'b1);
    send_word(1'b1, 12'h800);
    ticks(2);
    send_word(1'b1, 12'h7FF);
    ticks(1);
    drain();
    set_regs(4'd5, 2'd0, 1'b0);
    send_word(1'b1, 12'h001);
    ticks(2);

    // length shrunk below the running count mid-chirp: next sample is the last
    drain();
    set_regs(4'd5, 2'd1, 1'b0);
    send_word(1'b1, 12'($urandom));
    ticks($urandom_range(33, 50));
    drain();
    set_regs(4'd5, 2'd0, 1'b1);
    ticks(2);

    // random phases with varying idling
    goal = chirps.sample_total + RANDOM_SAMPLES;
    while (chirps.sample_total < goal) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 25;
        default: idle_pct = 50;
      endcase
      random_phase($urandom_range(1, 3));
    end

    // closing stretch at full rate
    idle_pct = 0;
    random_phase(3);
    drain();

    if (chirps.mismatches == 0 && chirps.outstanding() == 0) begin
      $display("chirp_symbol_generator_core_test: PASS");
    end else begin
      $display("chirp_symbol_generator_core_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("chirp_symbol_generator_core_test: FAIL");
    $finish;
  end

endmodule

// ===== chirp_symbol_generator_core.f =====
+incdir+src
src/csg_pkg.sv
src/chirp_symbol_generator_core.sv
sim/chirp_symbol_generator_core_test.sv
